[hw/rtl/crcfr_pkg.sv]
`default_nettype none
package crcfr_pkg;

    localparam int MAX_PAYLOAD_DEF = 64;
    localparam int BYTE_W          = 8;
    localparam int FLEN_W          = 7;
    localparam int STATUS_W        = 2;
    localparam int CFG_IDX_W       = 1;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] SOF_FIRST_RST  = 8'hAA;
    localparam logic [7:0] SOF_SECOND_RST = 8'h55;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SECOND = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] RES_NONE   = 2'd0;
    localparam logic [STATUS_W-1:0] RES_ITEM   = 2'd1;
    localparam logic [STATUS_W-1:0] RES_LENERR = 2'd2;
    localparam logic [STATUS_W-1:0] RES_CRCERR = 2'd3;

    typedef struct packed {
        logic                crc_init;
        logic                crc_upd;
        logic                len_lo_ld;
        logic                len_hi_ld;
        logic                fill_clr;
        logic                fill_wr;
        logic                rd_clr;
        logic                rd_issue;
        logic                rd_adv;
        logic                out_ld;
        logic                out_item;
        logic                out_last;
        logic [STATUS_W-1:0] out_status;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_sof_first;
        logic is_sof_second;
        logic len_big;
        logic len_in_zero;
        logic len_zero;
        logic fill_last;
        logic crc_lo_ok;
        logic crc_hi_ok;
        logic rd_last;
        logic out_free;
    } dp_stat_t;

    // CRC-16/CCITT-FALSE, one byte, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        c = crc ^ {d, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/crcfr_if.sv]
`default_nettype none
interface crcfr_rx_if;
    logic                            valid;
    logic                            ready;
    logic [crcfr_pkg::BYTE_W-1:0]    rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crcfr_res_if;
    logic                             valid;
    logic                             ready;
    logic [crcfr_pkg::STATUS_W-1:0]   status;
    logic [crcfr_pkg::BYTE_W-1:0]     payload_byte;
    logic [crcfr_pkg::FLEN_W-1:0]     frame_length;
    logic                             last;

    modport source (output valid, output status, output payload_byte,
                    output frame_length, output last, input ready);
    modport sink   (input valid, input status, input payload_byte,
                    input frame_length, input last, output ready);
endinterface
`default_nettype wire

[hw/rtl/crcfr_datapath.sv]
`default_nettype none
module crcfr_datapath #(
    parameter int MAX_PAYLOAD = crcfr_pkg::MAX_PAYLOAD_DEF
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire  [crcfr_pkg::BYTE_W-1:0]           rx_byte,
    input  wire                                    cfg_we,
    input  wire  [crcfr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [crcfr_pkg::BYTE_W-1:0]           cfg_data,
    input  crcfr_pkg::ctrl_cmd_t                   cmd,
    output crcfr_pkg::dp_stat_t                    stat,
    input  wire                                    out_ready,
    output logic                                   out_valid,
    output logic [crcfr_pkg::STATUS_W-1:0]         out_status,
    output logic [crcfr_pkg::BYTE_W-1:0]           out_payload_byte,
    output logic [crcfr_pkg::FLEN_W-1:0]           out_frame_length,
    output logic                                   out_last
);

    localparam int CNT_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int IDX_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int FLEN_W = crcfr_pkg::FLEN_W;

    logic [7:0]        sof_first_reg;
    logic [7:0]        sof_second_reg;
    logic [15:0]       crc_reg;
    logic [7:0]        len_lo_reg;
    logic [CNT_W-1:0]  len_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  rd_reg;
    logic [7:0]        mem_q_reg;
    logic              out_valid_reg;
    logic [crcfr_pkg::STATUS_W-1:0] out_status_reg;
    logic [7:0]        out_byte_reg;
    logic [FLEN_W-1:0] out_len_reg;
    logic              out_last_reg;

    logic [7:0]        payload_mem [MAX_PAYLOAD];

    logic [15:0]       len_full;
    logic [CNT_W:0]    fill_inc;
    logic [CNT_W:0]    rd_inc;

    assign len_full = {rx_byte, len_lo_reg};
    assign fill_inc = {1'b0, fill_reg} + 1'b1;
    assign rd_inc   = {1'b0, rd_reg} + 1'b1;

    always_comb
    begin
        stat.is_sof_first  = (rx_byte == sof_first_reg);
        stat.is_sof_second = (rx_byte == sof_second_reg);
        stat.len_big       = (len_full > 16'(MAX_PAYLOAD));
        stat.len_in_zero   = (len_full == 16'd0);
        stat.len_zero      = (len_reg == '0);
        stat.fill_last     = (fill_inc == {1'b0, len_reg});
        stat.crc_lo_ok     = (rx_byte == crc_reg[7:0]);
        stat.crc_hi_ok     = (rx_byte == crc_reg[15:8]);
        stat.rd_last       = (rd_inc == {1'b0, len_reg});
        stat.out_free      = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sof_first_reg  <= crcfr_pkg::SOF_FIRST_RST;
            sof_second_reg <= crcfr_pkg::SOF_SECOND_RST;
            crc_reg        <= crcfr_pkg::CRC_INIT;
            len_lo_reg     <= '0;
            len_reg        <= '0;
            fill_reg       <= '0;
            rd_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    crcfr_pkg::CFG_START_FIRST:  sof_first_reg  <= cfg_data;
                    crcfr_pkg::CFG_START_SECOND: sof_second_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.crc_init)
                crc_reg <= crcfr_pkg::CRC_INIT;
            else if (cmd.crc_upd)
                crc_reg <= crcfr_pkg::crc16_byte(crc_reg, rx_byte);
            if (cmd.len_lo_ld)
                len_lo_reg <= rx_byte;
            if (cmd.len_hi_ld)
                len_reg <= len_full[CNT_W-1:0];
            if (cmd.fill_clr)
                fill_reg <= '0;
            else if (cmd.fill_wr)
                fill_reg <= fill_inc[CNT_W-1:0];
            if (cmd.rd_clr)
                rd_reg <= '0;
            else if (cmd.rd_adv)
                rd_reg <= rd_inc[CNT_W-1:0];
            if (cmd.out_ld)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.fill_wr)
            payload_mem[fill_reg[IDX_W-1:0]] <= rx_byte;
        if (cmd.rd_issue)
            mem_q_reg <= payload_mem[rd_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_ld)
        begin
            out_status_reg <= cmd.out_status;
            out_byte_reg   <= cmd.out_item ? mem_q_reg : 8'd0;
            out_len_reg    <= cmd.out_item ? FLEN_W'(len_reg) : '0;
            out_last_reg   <= cmd.out_last;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_status       = out_status_reg;
    assign out_payload_byte = out_byte_reg;
    assign out_frame_length = out_len_reg;
    assign out_last         = out_last_reg;

endmodule
`default_nettype wire

[hw/rtl/crcfr_ctrl.sv]
`default_nettype none
module crcfr_ctrl (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  crcfr_pkg::dp_stat_t     stat,
    output crcfr_pkg::ctrl_cmd_t    cmd
);

    localparam logic [3:0] S_SOF0 = 4'd0;
    localparam logic [3:0] S_SOF1 = 4'd1;
    localparam logic [3:0] S_LEN0 = 4'd2;
    localparam logic [3:0] S_LEN1 = 4'd3;
    localparam logic [3:0] S_DATA = 4'd4;
    localparam logic [3:0] S_CRC0 = 4'd5;
    localparam logic [3:0] S_CRC1 = 4'd6;
    localparam logic [3:0] S_RD   = 4'd7;
    localparam logic [3:0] S_EMIT = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       receiving;
    logic       fire;

    assign receiving = (state_reg != S_RD) && (state_reg != S_EMIT);
    assign in_ready  = receiving && stat.out_free;
    assign fire      = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.out_last   = 1'b1;
        cmd.out_status = crcfr_pkg::RES_NONE;
        if (fire)
            cmd.out_ld = 1'b1;
        unique case (state_reg) inside
            S_SOF0:
            begin
                if (fire && stat.is_sof_first)
                begin
                    cmd.crc_init = 1'b1;
                    state_next   = S_SOF1;
                end
            end
            S_SOF1:
            begin
                if (fire)
                    state_next = stat.is_sof_second ? S_LEN0 : S_SOF0;
            end
            S_LEN0:
            begin
                if (fire)
                begin
                    cmd.len_lo_ld = 1'b1;
                    cmd.crc_upd   = 1'b1;
                    state_next    = S_LEN1;
                end
            end
            S_LEN1:
            begin
                if (fire)
                begin
                    cmd.len_hi_ld = 1'b1;
                    cmd.crc_upd   = 1'b1;
                    cmd.fill_clr  = 1'b1;
                    if (stat.len_big)
                    begin
                        cmd.out_status = crcfr_pkg::RES_LENERR;
                        state_next     = S_SOF0;
                    end
                    else
                        state_next = stat.len_in_zero ? S_CRC0 : S_DATA;
                end
            end
            S_DATA:
            begin
                if (fire)
                begin
                    cmd.fill_wr = 1'b1;
                    cmd.crc_upd = 1'b1;
                    if (stat.fill_last)
                        state_next = S_CRC0;
                end
            end
            S_CRC0, S_CRC1:
            begin
                if (fire)
                begin
                    if ((state_reg == S_CRC0) ? !stat.crc_lo_ok : !stat.crc_hi_ok)
                    begin
                        // failed byte may open the next frame
                        cmd.out_status = crcfr_pkg::RES_CRCERR;
                        if (stat.is_sof_first)
                        begin
                            cmd.crc_init = 1'b1;
                            state_next   = S_SOF1;
                        end
                        else
                            state_next = S_SOF0;
                    end
                    else if (state_reg == S_CRC0)
                        state_next = S_CRC1;
                    else if (stat.len_zero)
                    begin
                        cmd.out_status = crcfr_pkg::RES_ITEM;
                        state_next     = S_SOF0;
                    end
                    else
                    begin
                        // good frame: results come from the drain
                        cmd.out_ld = 1'b0;
                        cmd.rd_clr = 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_ld     = 1'b1;
                    cmd.out_item   = 1'b1;
                    cmd.out_status = crcfr_pkg::RES_ITEM;
                    cmd.out_last   = stat.rd_last;
                    cmd.rd_adv     = 1'b1;
                    state_next     = stat.rd_last ? S_SOF0 : S_RD;
                end
            end
            default:
            begin
                state_next = S_SOF0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_SOF0;
        else
            state_reg <= state_next;
    end

    a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_ld |-> stat.out_free)
        else $error("result loaded over a pending transaction");

    a_rd_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RD |=> state_reg == S_EMIT)
        else $error("store read not followed by emit");

    a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && !stat.out_free) |=> state_reg == S_EMIT)
        else $error("drain item dropped while output stalled");

    a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_ld && cmd.out_item && stat.rd_last) |=> state_reg == S_SOF0)
        else $error("drain did not return to hunting");

    a_no_accept_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD || state_reg == S_EMIT) |-> !fire)
        else $error("byte taken during drain");

endmodule
`default_nettype wire

[hw/rtl/crc_checked_frame_receiver.sv]
`default_nettype none
// Length-prefixed frame receiver with CRC-16/CCITT-FALSE check. Each rx
// transaction carries one byte and produces at least one res transaction.
// While a frame is being received one byte is taken per cycle, as long as
// the result register is free or being emptied. After a good frame with n
// payload bytes (n >= 1) the input is held off while the payload store
// drains: each stored byte takes a registered store read, then a result
// load that waits for a free result register. Lengths above MAX_PAYLOAD
// give a length error; CRC mismatches give a checksum error. Start bytes
// are set through the cfg write port (index 0 first, index 1 second start
// byte); write them only while idle, the block does not enforce it.
module crc_checked_frame_receiver #(
    parameter int MAX_PAYLOAD = crcfr_pkg::MAX_PAYLOAD_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    crcfr_rx_if.sink                            rx,
    crcfr_res_if.source                         res,
    input  wire                                 cfg_we,
    input  wire  [crcfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [crcfr_pkg::BYTE_W-1:0]        cfg_data
);

    crcfr_pkg::ctrl_cmd_t cmd;
    crcfr_pkg::dp_stat_t  stat;

    crcfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (rx.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    crcfr_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .rx_byte          (rx.rx_byte),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .stat             (stat),
        .out_ready        (res.ready),
        .out_valid        (res.valid),
        .out_status       (res.status),
        .out_payload_byte (res.payload_byte),
        .out_frame_length (res.frame_length),
        .out_last         (res.last)
    );

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
package crcfr_tb_pkg;
    import crcfr_pkg::*;

    typedef enum logic [2:0] {
        WAIT_FIRST,
        WAIT_SECOND,
        LEN_LO,
        LEN_HI,
        PAYLOAD,
        CRC_LO,
        CRC_HI
    } rx_phase_e;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   payload_byte;
        logic [FLEN_W-1:0]   frame_length;
        logic                last;
    } frame_result_t;

    // bit-serial form of CRC-16/CCITT-FALSE
    function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ d[i];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    class frame_scoreboard;
        logic [BYTE_W-1:0] sof_first;
        logic [BYTE_W-1:0] sof_second;
        rx_phase_e         phase;
        logic [15:0]       want_len;
        logic [FLEN_W-1:0] fill_idx;
        logic [15:0]       crc;
        logic [BYTE_W-1:0] store [MAX_PAYLOAD_DEF];
        frame_result_t     expected_q [$];
        int unsigned       n_errors;
        int unsigned       n_inputs;

        function new();
            sof_first  = SOF_FIRST_RST;
            sof_second = SOF_SECOND_RST;
            phase      = WAIT_FIRST;
            want_len   = '0;
            fill_idx   = '0;
            crc        = CRC_INIT;
            n_errors   = 0;
            n_inputs   = 0;
        endfunction

        function void set_start(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] v);
            if (idx == CFG_START_FIRST)
                sof_first = v;
            else
                sof_second = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void add_result(input logic [STATUS_W-1:0] st, input logic [BYTE_W-1:0] b,
                                 input logic [FLEN_W-1:0] len, input logic is_last);
            frame_result_t r;
            r.status       = st;
            r.payload_byte = b;
            r.frame_length = len;
            r.last         = is_last;
            expected_q.push_back(r);
        endfunction

        // one accepted rx transaction
        function void note_input(input logic [BYTE_W-1:0] b);
            logic quiet;
            quiet = 1'b1;
            n_inputs++;
            case (phase)
                WAIT_FIRST:
                begin
                    if (b == sof_first)
                    begin
                        phase = WAIT_SECOND;
                        crc   = CRC_INIT;
                    end
                end
                WAIT_SECOND:
                    phase = (b == sof_second) ? LEN_LO : WAIT_FIRST;
                LEN_LO:
                begin
                    want_len = {8'h00, b};
                    crc      = crc_next(crc, b);
                    phase    = LEN_HI;
                end
                LEN_HI:
                begin
                    want_len[15:8] = b;
                    crc            = crc_next(crc, b);
                    fill_idx       = '0;
                    if (want_len > MAX_PAYLOAD_DEF)
                    begin
                        // oversize length byte is not retried as a start byte
                        phase = WAIT_FIRST;
                        quiet = 1'b0;
                        add_result(RES_LENERR, '0, '0, 1'b1);
                    end
                    else
                        phase = (want_len == 0) ? CRC_LO : PAYLOAD;
                end
                PAYLOAD:
                begin
                    store[fill_idx[5:0]] = b;
                    fill_idx++;
                    crc = crc_next(crc, b);
                    if ({9'd0, fill_idx} >= want_len)
                        phase = CRC_LO;
                end
                CRC_LO, CRC_HI:
                begin
                    if (b != ((phase == CRC_LO) ? crc[7:0] : crc[15:8]))
                    begin
                        quiet = 1'b0;
                        add_result(RES_CRCERR, '0, '0, 1'b1);
                        // the failing byte may open the next frame
                        if (b == sof_first)
                        begin
                            phase = WAIT_SECOND;
                            crc   = CRC_INIT;
                        end
                        else
                            phase = WAIT_FIRST;
                    end
                    else if (phase == CRC_LO)
                        phase = CRC_HI;
                    else
                    begin
                        quiet = 1'b0;
                        phase = WAIT_FIRST;
                        if (want_len == 0)
                            add_result(RES_ITEM, '0, '0, 1'b1);
                        else
                            for (int i = 0; i < want_len; i++)
                                add_result(RES_ITEM, store[6'(i)], want_len[FLEN_W-1:0],
                                           i == want_len - 1);
                    end
                end
                default:
                begin
                    phase = WAIT_FIRST;
                    quiet = 1'b0;
                    add_result(RES_CRCERR, '0, '0, 1'b1);
                end
            endcase
            if (quiet)
                add_result(RES_NONE, '0, '0, 1'b1);
        endfunction

        // one accepted res transaction
        function void check_result(input frame_result_t got);
            frame_result_t exp_r;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: status %0d payload_byte %0h frame_length %0d last %0b",
                       got.status, got.payload_byte, got.frame_length, got.last);
                n_errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.status != exp_r.status)
            begin
                $error("status: expected %0d, got %0d", exp_r.status, got.status);
                n_errors++;
            end
            if (got.payload_byte != exp_r.payload_byte)
            begin
                $error("payload_byte: expected %0h, got %0h", exp_r.payload_byte, got.payload_byte);
                n_errors++;
            end
            if (got.frame_length != exp_r.frame_length)
            begin
                $error("frame_length: expected %0d, got %0d", exp_r.frame_length, got.frame_length);
                n_errors++;
            end
            if (got.last != exp_r.last)
            begin
                $error("last: expected %0b, got %0b", exp_r.last, got.last);
                n_errors++;
            end
        endfunction
    endclass

endpackage

module tb_top;
    import crcfr_pkg::*;
    import crcfr_tb_pkg::*;

    localparam int HOLD_CYCLES = 300;

    typedef enum {FRAME_OK, FRAME_BAD_CRC_LO, FRAME_BAD_CRC_HI, FRAME_CRC_RESYNC} frame_fault_e;
    typedef enum {RDY_ALWAYS, RDY_HALF, RDY_MOSTLY, RDY_SPARSE} ready_mode_e;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;
    logic                 hold_res;
    logic [BYTE_W-1:0]    start_first;
    logic [BYTE_W-1:0]    start_second;
    logic [BYTE_W-1:0]    tx_q [$];
    int unsigned          burst_left;
    frame_scoreboard      sb;

    crcfr_rx_if  rx();
    crcfr_res_if res();

    crc_checked_frame_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx.sink),
        .res       (res.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

    // transaction monitor; inputs are noted before results at the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rx.valid && rx.ready)
                sb.note_input(rx.rx_byte);
            if (res.valid && res.ready)
                sb.check_result(frame_result_t'{res.status, res.payload_byte,
                                                res.frame_length, res.last});
        end
    end

    // result side stall pattern
    initial
    begin
        ready_mode_e mode;
        int unsigned left;
        mode = RDY_ALWAYS;
        left = 0;
        res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                mode = ready_mode_e'($urandom_range(0, 3));
                left = $urandom_range(16, 96);
            end
            left--;
            case (mode)
                RDY_ALWAYS: res.ready <= ~hold_res;
                RDY_HALF:   res.ready <= ~hold_res & ($urandom_range(0, 1) == 1);
                RDY_MOSTLY: res.ready <= ~hold_res & ($urandom_range(0, 7) != 0);
                default:    res.ready <= ~hold_res & ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // long back-pressure stretches so the input side has to stall
    initial
    begin
        hold_res <= 1'b0;
        wait (rst_n === 1'b1);
        for (int k = 0; k < 2; k++)
        begin
            while (sb.n_inputs < 90 + 210 * k)
                @(posedge clk);
            hold_res <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_res <= 1'b0;
        end
    end

    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 8);
        else if (r < 92)
            return $urandom_range(9, 32);
        return $urandom_range(33, MAX_PAYLOAD_DEF);
    endfunction

    task automatic push_byte(input logic [BYTE_W-1:0] b);
        int unsigned gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                burst_left = $urandom_range(60, 120);
                gap        = 0;
            end
            else
            begin
                burst_left = $urandom_range(1, 24);
                gap        = $urandom_range(0, 8);
            end
            if (gap != 0)
            begin
                rx.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        do
            @(posedge clk);
        while (rx.ready !== 1'b1);
        burst_left--;
    endtask

    task automatic send_queued();
        while (tx_q.size() != 0)
            push_byte(tx_q.pop_front());
        rx.valid <= 1'b0;
    endtask

    // advance the clock first so the monitor has noted the last accepted byte
    task automatic wait_idle();
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_start_bytes(input logic [BYTE_W-1:0] first_byte,
                                   input logic [BYTE_W-1:0] second_byte);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_START_FIRST;
        cfg_data  <= first_byte;
        @(posedge clk);
        sb.set_start(CFG_START_FIRST, first_byte);
        cfg_index <= CFG_START_SECOND;
        cfg_data  <= second_byte;
        @(posedge clk);
        sb.set_start(CFG_START_SECOND, second_byte);
        cfg_we       <= 1'b0;
        start_first  = first_byte;
        start_second = second_byte;
    endtask

    // a resync fault leaves the receiver waiting for the second start byte;
    // the caller follows it with a frame that skips the first one
    task automatic add_frame(input int unsigned len, input frame_fault_e fault,
                             input bit skip_first = 1'b0);
        logic [15:0] crc;
        logic [7:0]  d;
        logic [7:0]  bad;
        if (!skip_first)
            tx_q.push_back(start_first);
        tx_q.push_back(start_second);
        crc = crc_next(CRC_INIT, len[7:0]);
        crc = crc_next(crc, len[15:8]);
        tx_q.push_back(len[7:0]);
        tx_q.push_back(len[15:8]);
        for (int i = 0; i < len; i++)
        begin
            d   = 8'($urandom_range(0, 255));
            crc = crc_next(crc, d);
            tx_q.push_back(d);
        end
        case (fault)
            FRAME_OK:
            begin
                tx_q.push_back(crc[7:0]);
                tx_q.push_back(crc[15:8]);
            end
            FRAME_BAD_CRC_LO:
            begin
                do
                    bad = 8'($urandom_range(0, 255));
                while (bad == crc[7:0] || bad == start_first);
                tx_q.push_back(bad);
            end
            FRAME_BAD_CRC_HI:
            begin
                tx_q.push_back(crc[7:0]);
                do
                    bad = 8'($urandom_range(0, 255));
                while (bad == crc[15:8] || bad == start_first);
                tx_q.push_back(bad);
            end
            default:
            begin
                if (crc[7:0] != start_first)
                    tx_q.push_back(start_first);
                else if (crc[15:8] != start_first)
                begin
                    tx_q.push_back(crc[7:0]);
                    tx_q.push_back(start_first);
                end
                else
                begin
                    tx_q.push_back(crc[7:0]);
                    tx_q.push_back(crc[15:8]);
                    tx_q.push_back(start_first);
                end
            end
        endcase
    endtask

    task automatic add_len_error(input logic [15:0] len16);
        tx_q.push_back(start_first);
        tx_q.push_back(start_second);
        tx_q.push_back(len16[7:0]);
        tx_q.push_back(len16[15:8]);
    endtask

    task automatic add_bad_second(input logic [7:0] b);
        tx_q.push_back(start_first);
        tx_q.push_back(b);
    endtask

    task automatic add_noise(input int unsigned n);
        logic [7:0] d;
        repeat (n)
        begin
            do
                d = 8'($urandom_range(0, 255));
            while (d == start_first);
            tx_q.push_back(d);
        end
    endtask

    task automatic add_random_traffic(input int unsigned budget);
        int unsigned pick;
        logic [7:0]  b;
        logic [15:0] len16;
        while (tx_q.size() < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                add_frame(pick_len(), FRAME_OK);
            else if (pick < 68)
                add_frame(pick_len(), FRAME_BAD_CRC_LO);
            else if (pick < 76)
                add_frame(pick_len(), FRAME_BAD_CRC_HI);
            else if (pick < 82)
            begin
                add_frame(pick_len(), FRAME_CRC_RESYNC);
                add_frame(pick_len(), FRAME_OK, 1'b1);
            end
            else if (pick < 88)
            begin
                len16[15:8] = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
                len16[7:0]  = (len16[15:8] == 8'h00) ? 8'($urandom_range(65, 255))
                                                     : 8'($urandom_range(0, 255));
                add_len_error(len16);
            end
            else if (pick < 94)
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == start_second);
                add_bad_second(b);
            end
            else if (pick < 98)
                add_noise($urandom_range(1, 4));
            else
                tx_q.push_back(8'($urandom_range(0, 255)));  // may land on a start byte
        end
    endtask

    task automatic run_phase(input logic [7:0] first_byte, input logic [7:0] second_byte,
                             input int unsigned budget);
        set_start_bytes(first_byte, second_byte);
        add_random_traffic(budget);
        send_queued();
        wait_idle();
    endtask

    initial
    begin
        sb = new();
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= CFG_START_FIRST;
        cfg_data   <= '0;
        rx.valid   <= 1'b0;
        rx.rx_byte <= '0;
        burst_left   = 0;
        start_first  = SOF_FIRST_RST;
        start_second = SOF_SECOND_RST;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset start bytes
        tx_q.push_back(8'h00);
        tx_q.push_back(8'hFF);
        add_frame(0, FRAME_OK);
        add_frame(1, FRAME_OK);
        add_frame(MAX_PAYLOAD_DEF, FRAME_OK);
        add_len_error(16'(MAX_PAYLOAD_DEF + 1));
        add_len_error(16'hFFFF);
        add_len_error({start_first, 8'h00});   // high length byte looks like a start byte
        add_frame(3, FRAME_BAD_CRC_LO);
        add_frame(5, FRAME_BAD_CRC_HI);
        add_frame(2, FRAME_CRC_RESYNC);
        add_frame(4, FRAME_OK, 1'b1);
        add_bad_second(8'h00);
        add_frame(4, FRAME_OK);
        add_bad_second(start_first);           // repeated first start byte is not retried
        tx_q.push_back(start_second);
        add_frame(1, FRAME_OK);
        send_queued();
        wait_idle();

        run_phase(SOF_FIRST_RST, SOF_SECOND_RST, 16);
        run_phase(8'h00, 8'hFF, 16);
        run_phase(8'hFF, 8'h00, 16);
        run_phase(8'h7E, 8'h7E, 16);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16);
        run_phase(SOF_FIRST_RST, SOF_SECOND_RST, 16);

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.n_errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
